FILE: rtl/core/gdcw_pkg.sv
// Package for the Gregorian date check and weekday block.
// Field widths, calendar constants, stage payload types and month tables.
// No dependencies.
package gdcw_pkg;

    // Field widths
    localparam int YearW   = 14;
    localparam int MonthW  = 4;
    localparam int DayW    = 5;
    localparam int HourW   = 5;
    localparam int MinuteW = 6;
    localparam int SecondW = 6;
    localparam int WdayW   = 3;

    // Quotient and remainder widths of a year split by 100
    localparam int CentW = 8;
    localparam int YyW   = 7;

    // Calendar limits
    localparam logic [YearW-1:0]   YearMax   = YearW'(9999);
    localparam logic [MonthW-1:0]  MonthMax  = MonthW'(12);
    localparam logic [HourW-1:0]   HourMax   = HourW'(23);
    localparam logic [MinuteW-1:0] MinuteMax = MinuteW'(59);
    localparam logic [SecondW-1:0] SecondMax = SecondW'(59);

    // Month numbers that need special handling
    localparam logic [MonthW-1:0] MonthFeb = MonthW'(2);

    // Reciprocal of 100: floor(y * 5243 / 2^19) == floor(y / 100) for y < 2^14
    localparam int RecipMul   = 5243;
    localparam int RecipShift = 19;
    localparam int RecipW     = 13;
    localparam int ProdW      = YearW + RecipW;

    // Payload after stage 1: range checks and year split
    typedef struct packed {
        logic              range_ok;
        logic [YyW-1:0]    yy;
        logic [1:0]        cent;
        logic [MonthW-1:0] month;
        logic [DayW-1:0]   day;
    } s1_t;

    // Payload after stage 2: leap year, day check, partial weekday terms
    typedef struct packed {
        logic            date_ok;
        logic            leap;
        logic [7:0]      ysum;
        logic [2:0]      mcode;
        logic [DayW-1:0] day;
    } s2_t;

    // Payload after stage 3: weekday sum folded once modulo 7
    typedef struct packed {
        logic       date_ok;
        logic       leap;
        logic [4:0] fold;
    } s3_t;

    // Days in a month, leap year aware; meaningless months give 31
    function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] month,
                                                 input logic leap);
        logic [DayW-1:0] len;
        begin
            unique case (month)
                4'd2:                     len = leap ? DayW'(29) : DayW'(28);
                4'd4, 4'd6, 4'd9, 4'd11:  len = DayW'(30);
                default:                  len = DayW'(31);
            endcase
            return len;
        end
    endfunction

    // Key-value month code; meaningless months give 0
    function automatic logic [2:0] month_code(input logic [MonthW-1:0] month);
        logic [2:0] code;
        begin
            unique case (month)
                4'd1:    code = 3'd1;
                4'd2:    code = 3'd4;
                4'd3:    code = 3'd4;
                4'd4:    code = 3'd0;
                4'd5:    code = 3'd2;
                4'd6:    code = 3'd5;
                4'd7:    code = 3'd0;
                4'd8:    code = 3'd3;
                4'd9:    code = 3'd6;
                4'd10:   code = 3'd1;
                4'd11:   code = 3'd4;
                4'd12:   code = 3'd6;
                default: code = 3'd0;
            endcase
            return code;
        end
    endfunction

endpackage

FILE: rtl/core/gdcw_date_if.sv
// Input channel carrying one date-time transaction.
// Depends on gdcw_pkg.
interface gdcw_date_if
    import gdcw_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [YearW-1:0]   year_value;
    logic [MonthW-1:0]  month_value;
    logic [DayW-1:0]    day_value;
    logic [HourW-1:0]   hour_value;
    logic [MinuteW-1:0] minute_value;
    logic [SecondW-1:0] second_value;

    modport source (
        output valid, year_value, month_value, day_value,
               hour_value, minute_value, second_value,
        input  ready
    );

    modport sink (
        input  valid, year_value, month_value, day_value,
               hour_value, minute_value, second_value,
        output ready
    );
endinterface

FILE: rtl/core/gdcw_result_if.sv
// Output channel carrying one check result transaction.
// Depends on gdcw_pkg.
interface gdcw_result_if
    import gdcw_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             date_valid;
    logic             leap_year;
    logic [WdayW-1:0] weekday;

    modport source (
        output valid, date_valid, leap_year, weekday,
        input  ready
    );

    modport sink (
        input  valid, date_valid, leap_year, weekday,
        output ready
    );
endinterface

FILE: rtl/core/gdcw_div100.sv
// Splits a year into century count and year within century.
// Divide by 100 through a reciprocal multiply; depends on gdcw_pkg.
module gdcw_div100
    import gdcw_pkg::*;
(
    input  logic [YearW-1:0] year,
    output logic [CentW-1:0] cent,
    output logic [YyW-1:0]   yy
);
    logic [ProdW-1:0] prod;
    logic [YearW-1:0] back;

    // Quotient from the high bits of the product
    assign prod = ProdW'(year) * ProdW'(RecipMul);
    assign cent = prod[RecipShift +: CentW];

    // Remainder: the quotient times 100 taken back off
    assign back = YearW'(cent) * YearW'(100);
    assign yy   = YyW'(year - back);
endmodule

FILE: rtl/core/gregorian_date_check_weekday_top.sv
// Gregorian date-time check with leap year flag and key-value weekday (0 Saturday).
// Depends on gdcw_pkg, gdcw_date_if, gdcw_result_if and gdcw_div100.

// The block takes one date-time transaction per cycle while the output side is not
// stalled and returns one result per transaction. The four register stages are: range
// checks with the divide by 100, leap year and month length with the year code sum,
// the weekday sum folded modulo 7, and the output register. Each stage holds while the
// one after it is full and stalled, so a new date is taken whenever any stage has room,
// including while a finished result waits at the output. The weekday field is 0 for an
// invalid date.
module gregorian_date_check_weekday_top
    import gdcw_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    gdcw_date_if.sink     date_item,
    gdcw_result_if.source check_result
);
    // Stage valid bits and enables
    logic v1_reg, v2_reg, v3_reg, vo_reg;
    logic en1, en2, en3, eno;

    s1_t s1_next, s1_reg;
    s2_t s2_next, s2_reg;
    s3_t s3_next, s3_reg;

    logic             date_valid_next, date_valid_reg;
    logic             leap_next, leap_reg;
    logic [WdayW-1:0] wday_next, wday_reg;

    logic [CentW-1:0] cent_full;
    logic [YyW-1:0]   yy_full;

    // A stage loads when it is empty or the next one loads
    assign eno = !vo_reg || check_result.ready;
    assign en3 = !v3_reg || eno;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign date_item.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= date_item.valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (eno) vo_reg <= v3_reg;
        end
    end

    // Stage 1: field range checks and year split
    gdcw_div100 u_div100 (
        .year (date_item.year_value),
        .cent (cent_full),
        .yy   (yy_full)
    );

    always_comb
    begin
        s1_next.range_ok = (date_item.year_value <= YearMax)
                        && (date_item.month_value != '0)
                        && (date_item.month_value <= MonthMax)
                        && (date_item.day_value != '0)
                        && (date_item.hour_value <= HourMax)
                        && (date_item.minute_value <= MinuteMax)
                        && (date_item.second_value <= SecondMax);
        s1_next.yy    = yy_full;
        s1_next.cent  = cent_full[1:0];
        s1_next.month = date_item.month_value;
        s1_next.day   = date_item.day_value;
    end

    // Stage 2: leap year, month length, year code sum, month code
    always_comb
    begin
        logic       leap;
        logic [2:0] ccode;
        logic [2:0] mcode;
        leap  = (s1_reg.yy == '0) ? (s1_reg.cent == 2'd0) : (s1_reg.yy[1:0] == 2'd0);
        ccode = 3'd6 - {s1_reg.cent, 1'b0};
        mcode = month_code(s1_reg.month);
        // Leap January and February lose one, i.e. add 6 modulo 7
        if (leap && (s1_reg.month <= MonthFeb))
            mcode = (mcode == 3'd0) ? 3'd6 : mcode - 3'd1;
        s2_next.leap    = leap;
        s2_next.date_ok = s1_reg.range_ok && (s1_reg.day <= month_len(s1_reg.month, leap));
        s2_next.ysum    = 8'(ccode) + 8'(s1_reg.yy) + 8'(s1_reg.yy[YyW-1:2]);
        s2_next.mcode   = mcode;
        s2_next.day     = s1_reg.day;
    end

    // Stage 3: full weekday sum, one fold modulo 7 (8 is 1 mod 7)
    always_comb
    begin
        logic [7:0] total;
        total = s2_reg.ysum + 8'(s2_reg.mcode) + 8'(s2_reg.day);
        s3_next.date_ok = s2_reg.date_ok;
        s3_next.leap    = s2_reg.leap;
        s3_next.fold    = 5'(total[7:3]) + 5'(total[2:0]);
    end

    // Output stage: second fold and final subtract
    always_comb
    begin
        logic [3:0] g;
        g = 4'(s3_reg.fold[4:3]) + 4'(s3_reg.fold[2:0]);
        if (g >= 4'd7)
            g = g - 4'd7;
        date_valid_next = s3_reg.date_ok;
        leap_next       = s3_reg.leap;
        wday_next       = s3_reg.date_ok ? g[WdayW-1:0] : '0;
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (en1) s1_reg <= s1_next;
        if (en2) s2_reg <= s2_next;
        if (en3) s3_reg <= s3_next;
        if (eno)
        begin
            date_valid_reg <= date_valid_next;
            leap_reg       <= leap_next;
            wday_reg       <= wday_next;
        end
    end

    assign check_result.valid      = vo_reg;
    assign check_result.date_valid = date_valid_reg;
    assign check_result.leap_year  = leap_reg;
    assign check_result.weekday    = wday_reg;
endmodule

FILE: tb/gregorian_date_check_weekday_top_test.sv
// Testbench for gregorian_date_check_weekday_top: a directed list of calendar corner dates,
// then random dates under four idling phases, each result checked against a local predictor.
// Depends on gdcw_pkg, gdcw_date_if, gdcw_result_if and the block's RTL.
module gregorian_date_check_weekday_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gdcw_pkg::*;

    localparam int ClkPeriod   = 10;
    localparam int ResetCycles = 7;
    localparam int DrainCycles = 20;
    localparam int CycleLimit  = 200000;
    localparam int RandomItems = 1200;

    // Weekday reported for an invalid date
    localparam logic [WdayW-1:0] WeekdayNone = WdayW'(0);

    typedef struct packed {
        logic [YearW-1:0]   year;
        logic [MonthW-1:0]  month;
        logic [DayW-1:0]    day;
        logic [HourW-1:0]   hour;
        logic [MinuteW-1:0] minute;
        logic [SecondW-1:0] second;
    } date_item_t;

    typedef struct packed {
        logic             date_valid;
        logic             leap_year;
        logic [WdayW-1:0] weekday;
    } verdict_t;

    // Scoreboard: predicts the verdict of each accepted date and checks results in order
    class verdict_board;
        verdict_t pending_verdicts[$];
        int       mismatches;
        int       checked;
        int       valid_dates;
        int       leap_dates;

        function new();
            mismatches  = 0;
            checked     = 0;
            valid_dates = 0;
            leap_dates  = 0;
        endfunction

        static function logic is_leap_year(int unsigned y);
            return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
        endfunction

        static function int unsigned month_days(int unsigned m, logic leap);
            case (m)
                2:              return leap ? 29 : 28;
                4, 6, 9, 11:    return 30;
                default:        return 31;
            endcase
        endfunction

        // Key-value month offset, before the leap January/February correction
        static function int unsigned month_key(int unsigned m);
            case (m)
                1, 10:      return 1;
                2, 3, 11:   return 4;
                5:          return 2;
                6:          return 5;
                8:          return 3;
                9, 12:      return 6;
                default:    return 0;
            endcase
        endfunction

        static function verdict_t calendar_verdict(date_item_t d);
            verdict_t    v;
            int unsigned y;
            int unsigned yy;
            int unsigned ccode;
            int unsigned ycode;
            int unsigned mcode;
            logic        ok;
            y            = d.year;
            v.leap_year  = is_leap_year(y);
            v.weekday    = WeekdayNone;
            ok = (d.year <= YearMax) && (d.month >= 1) && (d.month <= MonthMax) &&
                 (d.day >= 1) && (d.hour <= HourMax) && (d.minute <= MinuteMax) &&
                 (d.second <= SecondMax);
            if (ok && (d.day > month_days(d.month, v.leap_year)))
                ok = 1'b0;
            if (ok)
            begin
                yy    = y % 100;
                ccode = 6 - 2 * ((y / 100) % 4);
                ycode = (ccode + yy + yy / 4) % 7;
                mcode = month_key(d.month);
                if (v.leap_year && (d.month <= MonthFeb))
                    mcode = (mcode + 6) % 7;
                v.weekday = WdayW'((d.day + mcode + ycode) % 7);
            end
            v.date_valid = ok;
            return v;
        endfunction

        function void note_date(date_item_t d);
            verdict_t v;
            v = calendar_verdict(d);
            pending_verdicts.push_back(v);
            if (v.date_valid)
                valid_dates++;
            if (v.leap_year)
                leap_dates++;
        endfunction

        function void check_result(verdict_t got);
            verdict_t want;
            checked++;
            if (pending_verdicts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result valid=%0b leap=%0b weekday=%0d",
                             got.date_valid, got.leap_year, got.weekday);
                return;
            end
            want = pending_verdicts.pop_front();
            if (got != want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d expected valid=%0b leap=%0b weekday=%0d, got valid=%0b leap=%0b weekday=%0d",
                             checked, want.date_valid, want.leap_year, want.weekday,
                             got.date_valid, got.leap_year, got.weekday);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycle_count;
    int   send_idle_pct;
    int   recv_stall_pct;

    gdcw_date_if   date_bus();
    gdcw_result_if result_bus();

    verdict_board board;

    gregorian_date_check_weekday_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .date_item    (date_bus.sink),
        .check_result (result_bus.source)
    );

    // Clock
    initial clk = 1'b0;
    always #(ClkPeriod / 2) clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic date_item_t mk_date(int unsigned y, int unsigned m, int unsigned d,
                                           int unsigned h, int unsigned mi, int unsigned s);
        date_item_t item;
        item.year   = YearW'(y);
        item.month  = MonthW'(m);
        item.day    = DayW'(d);
        item.hour   = HourW'(h);
        item.minute = MinuteW'(mi);
        item.second = SecondW'(s);
        return item;
    endfunction

    function automatic int unsigned pick_edge(int unsigned a, int unsigned b,
                                              int unsigned c, int unsigned e);
        case ($urandom_range(3))
            0:       return a;
            1:       return b;
            2:       return c;
            default: return e;
        endcase
    endfunction

    // Random date: mostly well formed, some on the calendar edges, the rest raw bits
    function automatic date_item_t random_date();
        date_item_t  item;
        int unsigned kind;
        int unsigned y;
        int unsigned m;
        int unsigned len;
        kind = $urandom_range(99);
        if (kind < 60)
        begin
            y   = ($urandom_range(3) == 0) ? 100 * $urandom_range(99) : $urandom_range(9999);
            m   = $urandom_range(1, 12);
            len = verdict_board::month_days(m, verdict_board::is_leap_year(y));
            item = mk_date(y, m, $urandom_range(1, len), $urandom_range(23),
                           $urandom_range(59), $urandom_range(59));
        end
        else if (kind < 80)
        begin
            case ($urandom_range(3))
                0:       y = 400 * $urandom_range(24);
                1:       y = 100 * $urandom_range(99);
                2:       y = $urandom_range(9990, 10010);
                default: y = 4 * $urandom_range(2499);
            endcase
            m   = ($urandom_range(1) == 0) ? 2 : $urandom_range(1, 12);
            len = verdict_board::month_days(m, verdict_board::is_leap_year(y));
            item = mk_date(y, m, pick_edge(len - 1, len, len + 1, 1),
                           pick_edge(0, 23, 24, 31), pick_edge(0, 59, 60, 63),
                           pick_edge(0, 59, 60, 63));
        end
        else
        begin
            item = date_item_t'({$urandom, $urandom});
        end
        return item;
    endfunction

    // Offer one date transaction, idling first at the current rate; entered at a falling edge
    task automatic send_date(date_item_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            date_bus.valid <= 1'b0;
            @(negedge clk);
        end
        date_bus.valid        <= 1'b1;
        date_bus.year_value   <= item.year;
        date_bus.month_value  <= item.month;
        date_bus.day_value    <= item.day;
        date_bus.hour_value   <= item.hour;
        date_bus.minute_value <= item.minute;
        date_bus.second_value <= item.second;
        do
            @(posedge clk);
        while (!(date_bus.valid && date_bus.ready));
        board.note_date(item);
        @(negedge clk);
    endtask

    task automatic send_random_dates(int count);
        for (int i = 0; i < count; i++)
            send_date(random_date());
    endtask

    // Result side: stall at the current rate, check every accepted transaction
    initial
    begin
        result_bus.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
            @(posedge clk);
            if (result_bus.valid && result_bus.ready)
                board.check_result('{result_bus.date_valid, result_bus.leap_year,
                                     result_bus.weekday});
        end
    end

    // Main sequence
    initial
    begin
        date_item_t directed[$];
        int         failures;
        board          = new();
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n          = 1'b0;
        date_bus.valid        = 1'b0;
        date_bus.year_value   = '0;
        date_bus.month_value  = '0;
        date_bus.day_value    = '0;
        date_bus.hour_value   = '0;
        date_bus.minute_value = '0;
        date_bus.second_value = '0;
        repeat (ResetCycles) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed corners: year zero, last valid year, century leap rules,
        // out-of-range year still flagged for leap, zero and oversized fields
        directed.push_back(mk_date(0, 1, 1, 0, 0, 0));
        directed.push_back(mk_date(0, 2, 29, 12, 30, 30));
        directed.push_back(mk_date(9999, 12, 31, 23, 59, 59));
        directed.push_back(mk_date(2000, 2, 29, 0, 0, 0));
        directed.push_back(mk_date(1900, 2, 29, 0, 0, 0));
        directed.push_back(mk_date(1900, 2, 28, 0, 0, 0));
        directed.push_back(mk_date(2024, 2, 29, 8, 15, 0));
        directed.push_back(mk_date(2023, 2, 29, 8, 15, 0));
        directed.push_back(mk_date(2023, 7, 31, 1, 2, 3));
        directed.push_back(mk_date(2023, 4, 31, 1, 2, 3));
        directed.push_back(mk_date(2024, 1, 15, 10, 0, 0));
        directed.push_back(mk_date(2023, 0, 10, 0, 0, 0));
        directed.push_back(mk_date(2023, 13, 10, 0, 0, 0));
        directed.push_back(mk_date(2023, 15, 10, 0, 0, 0));
        directed.push_back(mk_date(2023, 5, 0, 0, 0, 0));
        directed.push_back(mk_date(2023, 5, 10, 24, 0, 0));
        directed.push_back(mk_date(2023, 5, 10, 0, 60, 0));
        directed.push_back(mk_date(2023, 5, 10, 0, 0, 60));
        directed.push_back(mk_date(10000, 1, 1, 0, 0, 0));
        directed.push_back(mk_date(12000, 2, 29, 0, 0, 0));
        directed.push_back(mk_date(16383, 15, 31, 31, 63, 63));
        directed.push_back(mk_date(0, 0, 0, 0, 0, 0));
        directed.push_back(mk_date(1600, 12, 31, 23, 59, 59));
        foreach (directed[i])
            send_date(directed[i]);

        // Four idling phases
        send_random_dates(RandomItems / 4);
        send_idle_pct  = 70;
        send_random_dates(RandomItems / 4);
        send_idle_pct  = 0;
        recv_stall_pct = 70;
        send_random_dates(RandomItems / 4);
        send_idle_pct  = 14;
        recv_stall_pct = 14;
        send_random_dates(RandomItems / 4);
        date_bus.valid <= 1'b0;

        // Drain outstanding results, then allow for the pipeline depth
        while (board.pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        failures = board.mismatches;
        if (board.pending_verdicts.size() != 0)
        begin
            $display("ERROR: %0d results never arrived", board.pending_verdicts.size());
            failures = failures + board.pending_verdicts.size();
        end
        $display("Checked %0d results: %0d valid dates, %0d leap years, %0d mismatches",
                 board.checked, board.valid_dates, board.leap_dates, board.mismatches);
        $display("Phases ran with no idling, sender idle, receiver stall and both mixed");
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/gdcw_pkg.sv
rtl/core/gdcw_date_if.sv
rtl/core/gdcw_result_if.sv
rtl/core/gdcw_div100.sv
rtl/core/gregorian_date_check_weekday_top.sv
tb/gregorian_date_check_weekday_top_test.sv
